/* rtl/mctt_pkg.sv */
`timescale 1ns / 1ps

package mctt_pkg;

  localparam int NumChannels = 8;

  localparam int CmdW      = 2;
  localparam int ChannelW  = 3;
  localparam int PeriodW   = 32;
  localparam int ExpiryW   = 8;

  typedef enum logic [CmdW-1:0] {
    CmdTick  = 2'd0,
    CmdStart = 2'd1,
    CmdStop  = 2'd2,
    CmdCheck = 2'd3
  } cmd_e;

  typedef logic [PeriodW-1:0] period_t;
  typedef logic [ExpiryW-1:0] expiry_t;

endpackage

/* rtl/multi_channel_tick_timer_bank.sv */
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid_i/in_ready_o | cmd_i, channel_i, period_i, periodic_i
// output   | out_valid_o/out_ready_i | ok_o
//
// One item per cycle: at the accepting edge a tick decrements every enabled lane
// and any other command acts on the addressed lane; the ok flag is registered, so
// the result is offered the next cycle. Each lane has its own 32-bit decrementer.
// Reset disables every channel and clears all counts and the result register.
// The input stalls only while a result is held and out_ready_i is low.

module multi_channel_tick_timer_bank
  import mctt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [ChannelW-1:0] channel_i,
  input  logic [PeriodW-1:0]  period_i,
  input  logic                periodic_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o
);

  period_t reload_q [NumChannels];
  period_t reload_d [NumChannels];
  period_t remain_q [NumChannels];
  period_t remain_d [NumChannels];
  expiry_t expiry_q [NumChannels];
  expiry_t expiry_d [NumChannels];
  logic [NumChannels-1:0] periodic_q, periodic_d;
  logic [NumChannels-1:0] en_q, en_d;
  logic [NumChannels-1:0] lane_ok;

  logic out_valid_q, out_valid_d;
  logic ok_q, ok_d;
  logic in_fire;
  cmd_e cmd;

  assign cmd        = cmd_e'(cmd_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    period_t rem_dec;
    logic    hit;
    for (int i = 0; i < NumChannels; i++) begin
      reload_d[i]   = reload_q[i];
      remain_d[i]   = remain_q[i];
      expiry_d[i]   = expiry_q[i];
      periodic_d[i] = periodic_q[i];
      en_d[i]       = en_q[i];
      lane_ok[i]    = 1'b0;
      rem_dec       = remain_q[i] - period_t'(1);
      hit           = (32'(channel_i) == i);
      if (in_fire) begin
        case (cmd)
          CmdTick: begin
            if (en_q[i]) begin
              remain_d[i] = rem_dec;
              if (rem_dec == '0) begin
                expiry_d[i] = expiry_q[i] + expiry_t'(1);
                if (periodic_q[i]) remain_d[i] = reload_q[i];
                else               en_d[i]     = 1'b0;
              end
            end
          end
          CmdStart: begin
            if (hit && period_i != '0 && !en_q[i]) begin
              reload_d[i]   = period_i;
              remain_d[i]   = period_i;
              periodic_d[i] = periodic_i;
              expiry_d[i]   = '0;
              en_d[i]       = 1'b1;
              lane_ok[i]    = 1'b1;
            end
          end
          CmdStop: begin
            if (hit) begin
              en_d[i]     = 1'b0;
              expiry_d[i] = '0;
              lane_ok[i]  = 1'b1;
            end
          end
          CmdCheck: begin
            if (hit && expiry_q[i] != '0) begin
              expiry_d[i] = expiry_q[i] - expiry_t'(1);
              lane_ok[i]  = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      ok_d        = |lane_ok;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      en_q        <= '0;
      periodic_q  <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        reload_q[i] <= '0;
        remain_q[i] <= '0;
        expiry_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      en_q        <= en_d;
      periodic_q  <= periodic_d;
      for (int i = 0; i < NumChannels; i++) begin
        reload_q[i] <= reload_d[i];
        remain_q[i] <= remain_d[i];
        expiry_q[i] <= expiry_d[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;

`ifndef SYNTHESIS
  a_tick_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == CmdTick) |=> (out_valid_q && !ok_q))
    else $error("tick item produced ok");

  a_stop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == CmdStop && 32'(channel_i) < NumChannels) |=> (out_valid_q && ok_q))
    else $error("stop item did not produce ok");

  a_enable_only_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(en_q) > $countones($past(en_q)))
      |-> $past(in_fire && cmd == CmdStart))
    else $error("channel enabled without a start item");

  a_idle_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> (en_q == $past(en_q)))
    else $error("channel enables changed without an item");
`endif

endmodule
